// File: sv/mvs_pkg.sv
// shared types and constants for the median of valid samples block
`timescale 1ns / 1ps

package mvs_pkg;

  // configuration register width and reset value
  localparam int MARKER_BITS = 16;
  localparam logic signed [MARKER_BITS-1:0] MARKER_RESET = -16'sd9999;

  // control state of the top level
  typedef enum logic {
    S_FILL,
    S_SHIFT
  } mvs_state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: sv/median_of_valid_samples.sv
// median of valid samples: sorted insertion chain with median readout
`timescale 1ns / 1ps
// usage
//   input channel (in_valid / in_ready) carries one word per sample plus a
//   last flag. a sample equal to the invalid marker register is skipped; any
//   other sample is inserted in ascending order into a chain of STORE_DEPTH
//   cells in the cycle it is accepted. once the chain is full further valid
//   samples are dropped and the overflow flag is set.
//   on the word flagged last the chain shifts toward cell 0 once per cycle
//   until the middle value sits in cell 0. once it does and the output
//   register is free, cells 0 and 1 (or cell 0 twice) are added into it.
//   non-last words are taken one per cycle outside the shift phase and
//   give no result.
//   in_ready is low only during the shift phase; the result word waits in the
//   output register while the receiver stalls, and new samples are accepted
//   meanwhile. a second result waits in the shift phase until the first leaves.
//   configuration (cfg_wr_en / cfg_wr_data) writes the marker at once.
//   reset empties the store, clears the overflow flag, sets the marker to
//   -9999 and drops any pending result word.
module median_of_valid_samples #(
  parameter int STORE_DEPTH = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // configuration
  input  logic                                       cfg_wr_en,
  input  logic signed [mvs_pkg::MARKER_BITS-1:0]     cfg_wr_data,
  // input words
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [SAMPLE_BITS-1:0]              in_sample,
  input  logic                                       in_last_item,
  // result words
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [SAMPLE_BITS:0]                out_median_doubled,
  output logic                                       out_none_valid,
  output logic [$clog2(STORE_DEPTH+1)-1:0]           out_valid_count,
  output logic                                       out_overflowed
);
  import mvs_pkg::*;

  localparam int CNT_BITS = $clog2(STORE_DEPTH + 1);
  localparam int CMP_BITS = (SAMPLE_BITS > MARKER_BITS) ? SAMPLE_BITS : MARKER_BITS;

  // control and configuration state
  mvs_state_t                    state_r, state_nxt;
  logic signed [MARKER_BITS-1:0] marker_r;
  logic [CNT_BITS-1:0]           count_r, count_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [CNT_BITS-1:0]           shift_cnt_r;

  // output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS:0]   med_r;
  logic                          none_r;
  logic [CNT_BITS-1:0]           cnt_out_r;
  logic                          ovf_out_r;

  cell_ctrl_t                    ctrl;
  logic                          load_res;
  logic                          in_fire;
  logic                          is_marker;
  logic                          store_ok;
  logic                          out_free;
  logic signed [SAMPLE_BITS:0]   med_sum;

  // chain wiring, each element tied to one cell
  logic signed [SAMPLE_BITS-1:0] cell_val  [STORE_DEPTH];
  logic                          cell_keep [STORE_DEPTH];

  // marker compare, both sign-extended to a common width
  assign is_marker = (CMP_BITS'(in_sample) == CMP_BITS'(marker_r));
  assign store_ok  = !is_marker && (count_r < CNT_BITS'(STORE_DEPTH));
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // next state and control
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctrl      = '0;
    load_res  = 1'b0;
    unique case (state_r)
      S_FILL: begin
        in_ready    = 1'b1;
        ctrl.insert = in_valid && store_ok;
        if (in_valid && in_last_item) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (shift_cnt_r != '0) begin
          ctrl.shift = 1'b1;
        end else if (out_free) begin
          load_res  = 1'b1;
          state_nxt = S_FILL;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // fill count and overflow flag
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (load_res) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (in_fire && !is_marker) begin
      if (store_ok) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      marker_r    <= MARKER_RESET;
      shift_cnt_r <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
      // shifts needed to bring the lower middle entry into cell 0
      if (in_fire && in_last_item) begin
        shift_cnt_r <= (count_nxt == '0) ? '0 : ((count_nxt - 1'b1) >> 1);
      end else if (ctrl.shift) begin
        shift_cnt_r <= shift_cnt_r - 1'b1;
      end
    end
  end

  // the cell row
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic                          occ;
    logic                          lk;
    logic signed [SAMPLE_BITS-1:0] lv;
    logic signed [SAMPLE_BITS-1:0] rv;

    assign occ = (count_r > CNT_BITS'(i));
    if (i == 0) begin : g_head
      assign lk = 1'b0;
      assign lv = in_sample;
    end else begin : g_body
      assign lk = cell_keep[i-1];
      assign lv = cell_val[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_tail
      assign rv = cell_val[i];
    end else begin : g_mid
      assign rv = cell_val[i+1];
    end

    mvs_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ),
      .sample   (in_sample),
      .left_keep(lk),
      .left_val (lv),
      .right_val(rv),
      .keep     (cell_keep[i]),
      .val      (cell_val[i])
    );
  end

  // odd count doubles the middle entry, even count adds the two middle ones, none gives zero
  always_comb begin
    if (count_r == '0) begin
      med_sum = '0;
    end else if (count_r[0]) begin
      med_sum = (SAMPLE_BITS+1)'(cell_val[0]) + (SAMPLE_BITS+1)'(cell_val[0]);
    end else begin
      med_sum = (SAMPLE_BITS+1)'(cell_val[0]) + (SAMPLE_BITS+1)'(cell_val[1]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      med_r     <= med_sum;
      none_r    <= (count_r == '0);
      cnt_out_r <= count_r;
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;
  assign out_none_valid     = none_r;
  assign out_valid_count    = cnt_out_r;
  assign out_overflowed     = ovf_out_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_last_shifts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_item) |=> (state_r == S_SHIFT))
    else $error("last word did not start the readout");

  a_shift_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && shift_cnt_r != '0) |=>
      (shift_cnt_r == $past(shift_cnt_r) - 1'b1))
    else $error("shift counter did not step");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |=> (count_r == '0 && !ovf_r && out_valid_r))
    else $error("store not emptied after result");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && none_r) |-> (med_r == '0 && cnt_out_r == '0))
    else $error("empty set gave nonzero result");

endmodule

// File: sv/mvs_cell.sv
// one cell of the sorted insertion chain
`timescale 1ns / 1ps

module mvs_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  mvs_pkg::cell_ctrl_t           ctrl,
  input  logic                          occupied,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          left_keep,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  output logic                          keep,
  output logic signed [SAMPLE_BITS-1:0] val
);
  import mvs_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_r;
  logic signed [SAMPLE_BITS-1:0] val_nxt;

  // an occupied cell not above the new sample stays put
  assign keep = occupied && (val_r <= sample);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    priority if (ctrl.insert) begin
      if (keep) begin
        val_nxt = val_r;
      end else if (left_keep) begin
        val_nxt = sample;
      end else begin
        val_nxt = left_val;
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end else begin
      // idle cycle, hold the value
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the median of valid samples block
`timescale 1ns / 1ps

module tb_top;
  import mvs_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);
  // worst case readout: the longest shift phase of a full store plus margin
  localparam int SETTLE_CYCLES = 150;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one input word as the driver presents it
  typedef struct {
    sample_t sample;
    logic    last;
  } sample_word_t;

  // one result word as the block should give it
  typedef struct {
    logic signed [SAMPLE_BITS:0] median2;
    logic                        none;
    logic [COUNT_BITS-1:0]       count;
    logic                        ovf;
  } median_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               cfg_wr_en = 1'b0;
  logic signed [MARKER_BITS-1:0]      cfg_wr_data = '0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  sample_t                            in_sample = '0;
  logic                               in_last_item = 1'b0;

  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [SAMPLE_BITS:0]        out_median_doubled;
  logic                               out_none_valid;
  logic [COUNT_BITS-1:0]              out_valid_count;
  logic                               out_overflowed;

  median_of_valid_samples #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_median_doubled (out_median_doubled),
    .out_none_valid     (out_none_valid),
    .out_valid_count    (out_valid_count),
    .out_overflowed     (out_overflowed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // words waiting for the driver, filled by the stimulus process
  sample_word_t words_pending[$];
  int words_queued = 0;
  int words_fed = 0;

  // predictor state: sorted copy of the stored samples, drop flag, marker
  sample_t ranked[$];
  logic    spilled = 1'b0;
  logic signed [MARKER_BITS-1:0] invalid_mark = MARKER_RESET;

  // results still owed by the block, oldest first
  median_word_t medians_due[$];
  int errors = 0;

  // handshake flags passed from the sampling edge to the driving edge
  bit in_took = 1'b0;
  bit out_took = 1'b0;

  int send_wait = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;

  // fold one accepted word into the predictor; a last word owes one result
  task automatic absorb_sample(sample_t s, logic last);
    int pos;
    int n;
    int m;
    median_word_t w;
    if (s != invalid_mark) begin
      if (ranked.size() < STORE_DEPTH) begin
        pos = 0;
        while (pos < ranked.size() && ranked[pos] <= s) pos++;
        ranked.insert(pos, s);
      end else begin
        // store full: the sample is lost but remembered as an overflow
        spilled = 1'b1;
      end
    end
    if (last) begin
      n = ranked.size();
      m = 0;
      if (n > 0) begin
        if (n % 2 == 1) m = 2 * int'(ranked[(n - 1) / 2]);
        else m = int'(ranked[n / 2 - 1]) + int'(ranked[n / 2]);
      end
      w.median2 = m[SAMPLE_BITS:0];
      w.none    = (n == 0);
      w.count   = n[COUNT_BITS-1:0];
      w.ovf     = spilled;
      medians_due.push_back(w);
      ranked.delete();
      spilled = 1'b0;
    end
  endtask

  // sampling edge: config writes, accepted input words and result checks
  always @(posedge clk) begin : sample_edge
    median_word_t w;
    if (rst_n) begin
      if (cfg_wr_en) invalid_mark = cfg_wr_data;
      if (in_valid && in_ready) begin
        absorb_sample(in_sample, in_last_item);
        words_fed++;
        in_took = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected result word: median2 %0d none %0b count %0d ovf %0b",
                   $time, out_median_doubled, out_none_valid, out_valid_count,
                   out_overflowed);
          errors++;
        end else begin
          w = medians_due.pop_front();
          if (out_median_doubled !== w.median2) begin
            $display("%0t: median_doubled expected %0d actual %0d",
                     $time, w.median2, out_median_doubled);
            errors++;
          end
          if (out_none_valid !== w.none) begin
            $display("%0t: none_valid expected %0b actual %0b",
                     $time, w.none, out_none_valid);
            errors++;
          end
          if (out_valid_count !== w.count) begin
            $display("%0t: valid_count expected %0d actual %0d",
                     $time, w.count, out_valid_count);
            errors++;
          end
          if (out_overflowed !== w.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b",
                     $time, w.ovf, out_overflowed);
            errors++;
          end
        end
      end
    end
  end

  // input driver: one word at a time, random gap after each word,
  // with calm stretches where words go back to back
  always @(negedge clk) begin : drive_in
    logic next_valid;
    sample_word_t wd;
    next_valid = in_valid;
    if (in_took) begin
      next_valid = 1'b0;
      in_took = 1'b0;
    end
    if (rst_n && !next_valid) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (words_pending.size() > 0) begin
        wd = words_pending.pop_front();
        in_sample <= wd.sample;
        in_last_item <= wd.last;
        next_valid = 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_wait = 0;
        end else begin
          send_wait = $urandom_range(0, 12);
          if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(10, 40);
        end
      end
    end
    in_valid <= next_valid;
  end

  // result receiver: may stall for a random time after each word, with calm stretches
  always @(negedge clk) begin : drive_out
    if (rst_n) begin
      if (out_took) begin
        out_took = 1'b0;
        if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, 12);
          if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(5, 20);
        end
        if (recv_wait > 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (recv_wait <= 1) out_ready <= 1'b1;
        if (recv_wait > 0) recv_wait--;
      end
    end
  end

  task automatic queue_word(sample_t s, logic last);
    sample_word_t wd;
    wd.sample = s;
    wd.last = last;
    words_pending.push_back(wd);
    words_queued++;
  endtask

  // random sample: extremes, a narrow band for ties, values next to the
  // marker, and full range; never the marker itself
  function automatic sample_t pick_sample(logic signed [MARKER_BITS-1:0] mk);
    sample_t v;
    do begin
      case ($urandom_range(0, 9))
        0: v = sample_t'(-32768);
        1: v = sample_t'(32767);
        2, 3: v = sample_t'($urandom_range(0, 8)) - sample_t'(4);
        4: v = ($urandom_range(0, 1) == 1) ? mk + 1'b1 : mk - 1'b1;
        default: v = sample_t'($urandom_range(0, 65535));
      endcase
    end while (v == mk);
    return v;
  endfunction

  // one data set of len words; each word is the marker with a chance of marker_pct percent
  task automatic queue_set(int len, int marker_pct, logic signed [MARKER_BITS-1:0] mk);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1, 100) <= marker_pct) s = mk;
      else s = pick_sample(mk);
      queue_word(s, i == len - 1);
    end
  endtask

  // wait until every queued word went in and every result came out, then
  // give the chain time to finish any shifting before touching the marker
  task automatic settle();
    while (words_fed != words_queued || medians_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_marker(logic signed [MARKER_BITS-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic signed [MARKER_BITS-1:0] mk;
    int phase_words;
    int len;
    int pct;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed sets under the reset marker
    // single sample at each extreme
    queue_word(sample_t'(32767), 1'b1);
    queue_word(sample_t'(-32768), 1'b1);
    // even count at each extreme, largest and smallest doubled median
    queue_word(sample_t'(32767), 1'b0);
    queue_word(sample_t'(32767), 1'b1);
    queue_word(sample_t'(-32768), 1'b0);
    queue_word(sample_t'(-32768), 1'b1);
    // set holding only the marker: no valid sample
    queue_word(MARKER_RESET, 1'b1);
    // marker around one valid sample, last word is itself skipped
    queue_word(MARKER_RESET, 1'b0);
    queue_word(sample_t'(5), 1'b0);
    queue_word(MARKER_RESET, 1'b1);
    // even count with duplicates out of order
    queue_word(sample_t'(3), 1'b0);
    queue_word(sample_t'(-1), 1'b0);
    queue_word(sample_t'(7), 1'b0);
    queue_word(sample_t'(-1), 1'b1);
    // opposite extremes give a half-LSB median
    queue_word(sample_t'(32767), 1'b0);
    queue_word(sample_t'(-32768), 1'b1);
    // values right next to the marker are kept
    queue_word(MARKER_RESET + 1'b1, 1'b0);
    queue_word(MARKER_RESET - 1'b1, 1'b0);
    queue_word(sample_t'(0), 1'b1);
    // ties at the middle
    queue_word(sample_t'(4), 1'b0);
    queue_word(sample_t'(4), 1'b0);
    queue_word(sample_t'(4), 1'b0);
    queue_word(sample_t'(2), 1'b1);
    settle();

    // random phases, each under its own marker
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: mk = -16'sd32768;
        1: mk = 16'sd32767;
        2: mk = '0;
        3: mk = -16'sd1;
        default: mk = MARKER_BITS'($urandom_range(0, 65535));
      endcase
      write_marker(mk);
      // full store: more valid samples than fit, some dropped
      if (p == 0) queue_set(300, 5, mk);
      // exactly a full store, count saturates without overflow
      if (p == 1) queue_set(STORE_DEPTH, 0, mk);
      phase_words = 0;
      while (phase_words < 110) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 60);
        else len = $urandom_range(1, 12);
        case ($urandom_range(0, 7))
          0: pct = 100;
          1, 2: pct = 50;
          3: pct = 0;
          default: pct = 12;
        endcase
        queue_set(len, pct, mk);
        phase_words += len;
      end
      settle();
    end

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/mvs_pkg.sv
sv/mvs_cell.sv
sv/median_of_valid_samples.sv
tb/sv/tb_top.sv
